// ===== sv/spi_addr24_meter_master_assert.svh =====
// ============================================================================
// Assertion macros for the serial meter master
// Shorthand for the clocked, reset-gated assertions used in the RTL.
// ============================================================================
`ifndef SPI_ADDR24_METER_MASTER_ASSERT_SVH
`define SPI_ADDR24_METER_MASTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SAM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SAM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sam_pkg.sv =====
// ============================================================================
// Serial meter master package
// Shared widths, codes, queue entry type and word fitting helpers.
// ============================================================================
package sam_pkg;

  localparam int DATA_BITS   = 24;
  localparam int HEADER_BITS = 8;
  localparam int TOTAL_BITS  = HEADER_BITS + DATA_BITS;
  localparam int WORD_W      = 24;
  localparam int SCALE_SHIFT = 13;
  localparam int SCALED_W    = WORD_W - SCALE_SHIFT;
  localparam int EXT_W       = (DATA_BITS > WORD_W) ? DATA_BITS : WORD_W;
  localparam int BCNT_W      = $clog2(DATA_BITS + 1);
  localparam int DELAY_W     = 16;
  localparam int CFG_IDX_W   = 2;

  // Header bit rules for writes and reads.
  localparam logic [HEADER_BITS-1:0] WR_SET  = 8'h80;
  localparam logic [HEADER_BITS-1:0] WR_CLR  = 8'h40;
  localparam logic [HEADER_BITS-1:0] RD_MASK = 8'h7F;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_WIRE   = 2'd2;

  localparam logic [DELAY_W-1:0] LONG_DELAY_RST  = 16'd1000;
  localparam logic [DELAY_W-1:0] HALF_PERIOD_RST = 16'd4;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_CMD   = 2'd3
  } op_t;

  // One classified tick waiting for the frame sequencer.
  typedef struct packed {
    op_t                    op;
    logic [HEADER_BITS-1:0] hdr;
    logic [DATA_BITS-1:0]   data;
    logic                   miso;
  } entry_t;

  function automatic logic [DATA_BITS-1:0] fit_data(input logic [WORD_W-1:0] w);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(w);
    return ext[DATA_BITS-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] fit_word(input logic [DATA_BITS-1:0] d);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(d);
    return ext[WORD_W-1:0];
  endfunction

endpackage

// ===== sv/sam_if.sv =====
// ============================================================================
// Serial meter master channel interfaces
// Tick request channel and pin result channel, valid/ready handshake.
// ============================================================================
interface sam_in_if;
  import sam_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             func;
  logic [HEADER_BITS-1:0] reg_addr;
  logic [WORD_W-1:0]      write_value;
  logic                   miso_bit;

  modport source (output valid, func, reg_addr, write_value, miso_bit, input ready);
  modport sink   (input valid, func, reg_addr, write_value, miso_bit, output ready);
endinterface

interface sam_out_if;
  import sam_pkg::*;

  logic                valid;
  logic                ready;
  logic                cs_n;
  logic                sclk;
  logic                mosi;
  logic                mode_pin;
  logic                busy_res;
  logic                done_res;
  logic [WORD_W-1:0]   read_value;
  logic [SCALED_W-1:0] scaled_value;

  modport source (output valid, cs_n, sclk, mosi, mode_pin, busy_res, done_res,
                  read_value, scaled_value, input ready);
  modport sink   (input valid, cs_n, sclk, mosi, mode_pin, busy_res, done_res,
                  read_value, scaled_value, output ready);
endinterface

// ===== sv/spi_addr24_meter_master.sv =====
// ============================================================================
// Serial meter master, mode-1 clocking, 8-bit header and 24-bit data word
// Tick-driven master: each request beat is one clock tick of the serial
// frame, and each result beat carries the pin levels after that tick.
// ============================================================================
//
//   Channel  Dir   Beat contents
//   -------  ----  ------------------------------------------------------------
//   tick     in    func, reg_addr, write_value, miso_bit (one tick per beat)
//   pins     out   cs_n, sclk, mosi, mode_pin, busy_res, done_res, read_value,
//                  scaled_value (pin levels and status after that tick)
//   cfg      in    write enable, register index, 16-bit data (no read-back)
//
// One tick beat is accepted every cycle while the queue has room. Each beat
// yields one result beat via the two-entry queue and the sequencer's output
// register. The frame sequencer performs exactly one frame step per beat.
// Reset (rst, synchronous) returns chip select high, clock and data low, the
// sequencer idle, the stored read word zero and the queue empty.
// When pins stalls, the queue fills and then tick's ready drops; a stall on
// tick only leaves the sequencer without work and holds all frame state.
//
// The front end decodes the request and builds the header: a write forces the
// top header bit high and the next one low, a read clears the top bit, and a
// command goes out unchanged. Requests arriving while a frame is in progress
// are dropped by the sequencer, which only looks at the request in its idle
// phase. Configuration writes take effect on waits that start afterwards.
//
module spi_addr24_meter_master (
  input  logic                          clk,
  input  logic                          rst,
  sam_in_if.sink                        tick,
  sam_out_if.source                     pins,
  input  logic                          cfg_wen,
  input  logic [sam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sam_pkg::DELAY_W-1:0]   cfg_data
);
  import sam_pkg::*;

  // Configuration registers.
  logic [DELAY_W-1:0] long_delay;
  logic [DELAY_W-1:0] half_period;
  logic               four_wire;

  // Front end to queue.
  logic   fq_valid;
  logic   fq_ready;
  entry_t fq_ent;

  // Queue to sequencer.
  logic   qb_valid;
  logic   qb_ready;
  entry_t qb_ent;

  // An index past the end of the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_delay  <= LONG_DELAY_RST;
      half_period <= HALF_PERIOD_RST;
      four_wire   <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_LONG_DELAY:  long_delay  <= cfg_data;
        CFG_HALF_PERIOD: half_period <= cfg_data;
        CFG_FOUR_WIRE:   four_wire   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sam_front u_front (
    .tick    (tick),
    .q_valid (fq_valid),
    .q_ready (fq_ready),
    .q_ent   (fq_ent)
  );

  sam_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_ent    (fq_ent),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_ent   (qb_ent)
  );

  sam_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (qb_valid),
    .q_ready     (qb_ready),
    .q_ent       (qb_ent),
    .long_delay  (long_delay),
    .half_period (half_period),
    .four_wire   (four_wire),
    .pins        (pins)
  );

endmodule

// ===== sv/sam_front.sv =====
// ============================================================================
// Serial meter master front end
// Takes tick beats, decodes the request and formats the frame header/data.
// ============================================================================
module sam_front (
  sam_in_if.sink          tick,
  output logic            q_valid,
  input  logic            q_ready,
  output sam_pkg::entry_t q_ent
);
  import sam_pkg::*;

  op_t op;

  assign op         = op_t'(tick.func);
  assign q_valid    = tick.valid;
  assign tick.ready = q_ready;

  always_comb begin
    q_ent.op   = op;
    q_ent.miso = tick.miso_bit;
    q_ent.hdr  = tick.reg_addr;
    q_ent.data = '0;
    case (op)
      OP_WRITE: begin
        q_ent.hdr  = (tick.reg_addr | WR_SET) & ~WR_CLR;
        q_ent.data = fit_data(tick.write_value);
      end
      OP_READ: begin
        q_ent.hdr = tick.reg_addr & RD_MASK;
      end
      default: begin
        q_ent.hdr = tick.reg_addr;
      end
    endcase
  end

endmodule

// ===== sv/sam_queue.sv =====
// ============================================================================
// Serial meter master decoupling queue
// Two-entry queue between the front end and the frame sequencer.
// ============================================================================
module sam_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sam_pkg::entry_t in_ent,
  output logic            out_valid,
  input  logic            out_ready,
  output sam_pkg::entry_t out_ent
);
  import sam_pkg::*;

  entry_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_ent   = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/sam_back.sv =====
// ============================================================================
// Serial meter master frame sequencer
// Advances the frame one tick per queued beat and registers the pin levels.
// ============================================================================
module sam_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  sam_pkg::entry_t              q_ent,
  input  logic [sam_pkg::DELAY_W-1:0]  long_delay,
  input  logic [sam_pkg::DELAY_W-1:0]  half_period,
  input  logic                         four_wire,
  sam_out_if.source                    pins
);
  import sam_pkg::*;

  `include "spi_addr24_meter_master_assert.svh"

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_SETTLE, PH_HDR_HI, PH_HDR_LO,
    PH_TURN, PH_DAT_HI, PH_DAT_LO, PH_TAIL
  } phase_t;

  phase_t                phase, phase_next;
  op_t                   op_kind, op_kind_next;
  logic [BCNT_W-1:0]     bit_count, bit_count_next;
  logic [DELAY_W-1:0]    wait_count, wait_count_next;
  logic [TOTAL_BITS-1:0] tx_shift, tx_shift_next;
  logic [DATA_BITS-1:0]  rx_shift, rx_shift_next;
  logic [WORD_W-1:0]     last_read, last_read_next;
  logic                  cs, cs_next;
  logic                  clk_pin, clk_pin_next;
  logic                  dat, dat_next;
  logic                  done_next;
  logic                  pop;

  // Step request flags: a rising clock edge into a phase, or a plain wait.
  logic                  do_rise;
  phase_t                rise_ph;
  logic                  do_enter;
  phase_t                ent_ph;
  logic [DELAY_W-1:0]    ent_dur;
  logic [BCNT_W-1:0]     bc_dec;

  assign pop     = q_valid && (!pins.valid || pins.ready);
  assign q_ready = pop;
  assign bc_dec  = (bit_count != '0) ? bit_count - 1'b1 : bit_count;

  always_comb begin
    phase_next      = phase;
    op_kind_next    = op_kind;
    bit_count_next  = bit_count;
    wait_count_next = wait_count;
    tx_shift_next   = tx_shift;
    rx_shift_next   = rx_shift;
    last_read_next  = last_read;
    cs_next         = cs;
    clk_pin_next    = clk_pin;
    dat_next        = dat;
    done_next       = 1'b0;
    do_rise         = 1'b0;
    rise_ph         = PH_HDR_HI;
    do_enter        = 1'b0;
    ent_ph          = PH_IDLE;
    ent_dur         = half_period;

    if (phase == PH_IDLE) begin
      if (q_ent.op != OP_NONE) begin
        op_kind_next   = q_ent.op;
        tx_shift_next  = {q_ent.hdr, q_ent.data};
        rx_shift_next  = '0;
        bit_count_next = BCNT_W'(HEADER_BITS);
        cs_next        = 1'b1;
        clk_pin_next   = 1'b0;
        dat_next       = 1'b0;
        do_enter       = 1'b1;
        ent_ph         = PH_PRE;
        ent_dur        = long_delay;
      end
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - 1'b1;
    end else begin
      case (phase)
        PH_PRE: begin
          cs_next  = 1'b0;
          do_enter = 1'b1;
          ent_ph   = PH_SETTLE;
          ent_dur  = long_delay;
        end
        PH_SETTLE: begin
          do_rise = 1'b1;
          rise_ph = PH_HDR_HI;
        end
        PH_HDR_HI: begin
          clk_pin_next = 1'b0;
          do_enter     = 1'b1;
          ent_ph       = PH_HDR_LO;
        end
        PH_HDR_LO: begin
          bit_count_next = bc_dec;
          if (bc_dec != '0) begin
            do_rise = 1'b1;
            rise_ph = PH_HDR_HI;
          end else begin
            bit_count_next = BCNT_W'(DATA_BITS);
            if (op_kind == OP_READ) begin
              dat_next = 1'b0;
              do_enter = 1'b1;
              ent_ph   = PH_TURN;
              ent_dur  = long_delay;
            end else begin
              do_rise = 1'b1;
              rise_ph = PH_DAT_HI;
            end
          end
        end
        PH_TURN: begin
          do_rise = 1'b1;
          rise_ph = PH_DAT_HI;
        end
        PH_DAT_HI: begin
          clk_pin_next = 1'b0;
          if (op_kind == OP_READ) begin
            rx_shift_next = {rx_shift[DATA_BITS-2:0], q_ent.miso};
          end
          do_enter = 1'b1;
          ent_ph   = PH_DAT_LO;
        end
        PH_DAT_LO: begin
          bit_count_next = bc_dec;
          if (bc_dec != '0) begin
            do_rise = 1'b1;
            rise_ph = PH_DAT_HI;
          end else begin
            clk_pin_next = 1'b0;
            dat_next     = 1'b0;
            do_enter     = 1'b1;
            ent_ph       = PH_TAIL;
          end
        end
        default: begin
          // End of the tail: release chip select and close the frame.
          cs_next         = 1'b1;
          clk_pin_next    = 1'b0;
          dat_next        = 1'b0;
          if ((phase == PH_TAIL) && (op_kind == OP_READ)) begin
            last_read_next = fit_word(rx_shift);
          end
          done_next       = (phase == PH_TAIL);
          phase_next      = PH_IDLE;
          wait_count_next = '0;
          bit_count_next  = '0;
        end
      endcase
    end

    if (do_rise) begin
      clk_pin_next  = 1'b1;
      dat_next      = tx_shift[TOTAL_BITS-1];
      tx_shift_next = {tx_shift[TOTAL_BITS-2:0], 1'b0};
      do_enter      = 1'b1;
      ent_ph        = rise_ph;
      ent_dur       = half_period;
    end
    if (do_enter) begin
      phase_next      = ent_ph;
      wait_count_next = (ent_dur != '0) ? ent_dur - 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      op_kind    <= OP_NONE;
      bit_count  <= '0;
      wait_count <= '0;
      tx_shift   <= '0;
      rx_shift   <= '0;
      last_read  <= '0;
      cs         <= 1'b1;
      clk_pin    <= 1'b0;
      dat        <= 1'b0;
      pins.valid <= 1'b0;
    end else begin
      if (pop) begin
        phase             <= phase_next;
        op_kind           <= op_kind_next;
        bit_count         <= bit_count_next;
        wait_count        <= wait_count_next;
        tx_shift          <= tx_shift_next;
        rx_shift          <= rx_shift_next;
        last_read         <= last_read_next;
        cs                <= cs_next;
        clk_pin           <= clk_pin_next;
        dat               <= dat_next;
        pins.valid        <= 1'b1;
        pins.cs_n         <= cs_next;
        pins.sclk         <= clk_pin_next;
        pins.mosi         <= dat_next;
        pins.mode_pin     <= four_wire;
        pins.busy_res     <= (phase_next != PH_IDLE);
        pins.done_res     <= done_next;
        pins.read_value   <= last_read_next;
        pins.scaled_value <= last_read_next[WORD_W-1:SCALE_SHIFT];
      end else if (pins.ready) begin
        pins.valid <= 1'b0;
      end
    end
  end

  `SAM_ASSERT_IMP(a_idle_pins, phase == PH_IDLE, cs && !clk_pin,
                  "idle sequencer must hold chip select high and clock low")
  `SAM_ASSERT_IMP(a_clk_needs_cs, clk_pin, !cs,
                  "serial clock high while chip select is released")
  `SAM_ASSERT_NXT(a_start_frame, pop && (phase == PH_IDLE) && (q_ent.op != OP_NONE),
                  phase == PH_PRE, "accepted request did not start a frame")
  `SAM_ASSERT_IMP(a_bit_count_range, 1'b1, bit_count <= BCNT_W'(DATA_BITS),
                  "bit counter beyond the data word length")

endmodule

// ===== verif/spi_addr24_meter_master_chk.sv =====
// ============================================================================
// Serial meter master pin checker
// Watches the tick, pin and configuration ports, steps its own copy of the
// frame sequencer for every accepted tick beat and compares each pin beat
// with the oldest predicted one.
// ============================================================================
module spi_addr24_meter_master_chk
  import sam_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sam_in_if                    tick,
  sam_out_if                   pins,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_PRE, SEQ_SETTLE, SEQ_HDR_HI, SEQ_HDR_LO,
    SEQ_TURN, SEQ_DAT_HI, SEQ_DAT_LO, SEQ_TAIL
  } seq_t;

  typedef struct packed {
    logic                cs_n;
    logic                sclk;
    logic                mosi;
    logic                mode_pin;
    logic                busy_res;
    logic                done_res;
    logic [WORD_W-1:0]   read_value;
    logic [SCALED_W-1:0] scaled_value;
  } pin_beat_t;

  // Shadow configuration.
  logic [DELAY_W-1:0] long_ticks;
  logic [DELAY_W-1:0] half_ticks;
  logic               four_wire;

  // Shadow frame state.
  seq_t                  seq;
  op_t                   frame_op;
  logic [BCNT_W-1:0]     bits_left;
  logic [DELAY_W-1:0]    hold;
  logic [TOTAL_BITS-1:0] tx_bits;
  logic [DATA_BITS-1:0]  rx_bits;
  logic [WORD_W-1:0]     last_word;
  logic                  pin_cs;
  logic                  pin_clk;
  logic                  pin_dat;

  pin_beat_t pin_q[$];

  task reset_shadow();
    long_ticks = LONG_DELAY_RST;
    half_ticks = HALF_PERIOD_RST;
    four_wire  = 1'b0;
    seq        = SEQ_IDLE;
    frame_op   = OP_NONE;
    bits_left  = '0;
    hold       = '0;
    tx_bits    = '0;
    rx_bits    = '0;
    last_word  = '0;
    pin_cs     = 1'b1;
    pin_clk    = 1'b0;
    pin_dat    = 1'b0;
  endtask

  // A wait of D ticks holds its pins for D ticks including the one that set
  // them; a zero length behaves as one tick.
  task start_wait(input seq_t nxt, input logic [DELAY_W-1:0] dur);
    seq  = nxt;
    hold = (dur == '0) ? '0 : dur - 1'b1;
  endtask

  task clock_out(input seq_t nxt);
    pin_clk = 1'b1;
    pin_dat = tx_bits[TOTAL_BITS-1];
    tx_bits = tx_bits << 1;
    start_wait(nxt, half_ticks);
  endtask

  task step_frame(input logic [1:0] func, input logic [HEADER_BITS-1:0] addr,
                  input logic [WORD_W-1:0] wval, input logic miso,
                  output pin_beat_t res);
    logic [HEADER_BITS-1:0] hdr;
    logic [DATA_BITS-1:0]   payload;
    logic                   done;
    done = 1'b0;
    if (seq == SEQ_IDLE) begin
      if (op_t'(func) != OP_NONE) begin
        hdr     = addr;
        payload = '0;
        if (op_t'(func) == OP_WRITE) begin
          hdr     = (addr | WR_SET) & ~WR_CLR;
          payload = wval[DATA_BITS-1:0];
        end else if (op_t'(func) == OP_READ) begin
          hdr = addr & RD_MASK;
        end
        frame_op  = op_t'(func);
        tx_bits   = {hdr, payload};
        rx_bits   = '0;
        bits_left = BCNT_W'(HEADER_BITS);
        pin_cs    = 1'b1;
        pin_clk   = 1'b0;
        pin_dat   = 1'b0;
        start_wait(SEQ_PRE, long_ticks);
      end
    end else if (hold != '0) begin
      hold = hold - 1'b1;
    end else begin
      case (seq)
        SEQ_PRE: begin
          pin_cs = 1'b0;
          start_wait(SEQ_SETTLE, long_ticks);
        end
        SEQ_SETTLE: clock_out(SEQ_HDR_HI);
        SEQ_HDR_HI: begin
          pin_clk = 1'b0;
          start_wait(SEQ_HDR_LO, half_ticks);
        end
        SEQ_HDR_LO: begin
          if (bits_left != '0) bits_left = bits_left - 1'b1;
          if (bits_left != '0) begin
            clock_out(SEQ_HDR_HI);
          end else begin
            bits_left = BCNT_W'(DATA_BITS);
            if (frame_op == OP_READ) begin
              pin_dat = 1'b0;
              start_wait(SEQ_TURN, long_ticks);
            end else begin
              clock_out(SEQ_DAT_HI);
            end
          end
        end
        SEQ_TURN: clock_out(SEQ_DAT_HI);
        SEQ_DAT_HI: begin
          pin_clk = 1'b0;
          if (frame_op == OP_READ) rx_bits = {rx_bits[DATA_BITS-2:0], miso};
          start_wait(SEQ_DAT_LO, half_ticks);
        end
        SEQ_DAT_LO: begin
          if (bits_left != '0) bits_left = bits_left - 1'b1;
          if (bits_left != '0) begin
            clock_out(SEQ_DAT_HI);
          end else begin
            pin_clk = 1'b0;
            pin_dat = 1'b0;
            start_wait(SEQ_TAIL, half_ticks);
          end
        end
        default: begin
          pin_cs  = 1'b1;
          pin_clk = 1'b0;
          pin_dat = 1'b0;
          if (seq == SEQ_TAIL && frame_op == OP_READ) last_word = rx_bits[WORD_W-1:0];
          done      = (seq == SEQ_TAIL);
          seq       = SEQ_IDLE;
          hold      = '0;
          bits_left = '0;
        end
      endcase
    end
    res.cs_n         = pin_cs;
    res.sclk         = pin_clk;
    res.mosi         = pin_dat;
    res.mode_pin     = four_wire;
    res.busy_res     = (seq != SEQ_IDLE);
    res.done_res     = done;
    res.read_value   = last_word;
    res.scaled_value = SCALED_W'(last_word >> SCALE_SHIFT);
  endtask

  task mismatch(input string name, input logic [WORD_W-1:0] want,
                input logic [WORD_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  always @(posedge clk) begin : watch
    pin_beat_t want;
    pin_beat_t res;
    if (rst) begin
      reset_shadow();
      pin_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      // Pop before push: a pin beat never belongs to a tick of the same edge.
      if (pins.valid && pins.ready) begin
        if (pin_q.size() == 0) begin
          errors++;
          $display("%0t: pin beat with no tick waiting for it", $time);
        end else begin
          want = pin_q.pop_front();
          if (pins.cs_n !== want.cs_n)
            mismatch("cs_n", WORD_W'(want.cs_n), WORD_W'(pins.cs_n));
          if (pins.sclk !== want.sclk)
            mismatch("sclk", WORD_W'(want.sclk), WORD_W'(pins.sclk));
          if (pins.mosi !== want.mosi)
            mismatch("mosi", WORD_W'(want.mosi), WORD_W'(pins.mosi));
          if (pins.mode_pin !== want.mode_pin)
            mismatch("mode_pin", WORD_W'(want.mode_pin), WORD_W'(pins.mode_pin));
          if (pins.busy_res !== want.busy_res)
            mismatch("busy_res", WORD_W'(want.busy_res), WORD_W'(pins.busy_res));
          if (pins.done_res !== want.done_res)
            mismatch("done_res", WORD_W'(want.done_res), WORD_W'(pins.done_res));
          if (pins.read_value !== want.read_value)
            mismatch("read_value", want.read_value, pins.read_value);
          if (pins.scaled_value !== want.scaled_value)
            mismatch("scaled_value", WORD_W'(want.scaled_value),
                     WORD_W'(pins.scaled_value));
        end
      end
      if (tick.valid && tick.ready) begin
        step_frame(tick.func, tick.reg_addr, tick.write_value, tick.miso_bit, res);
        pin_q.push_back(res);
      end
      if (cfg_wen) begin
        case (cfg_index)
          CFG_LONG_DELAY:  long_ticks = cfg_data;
          CFG_HALF_PERIOD: half_ticks = cfg_data;
          CFG_FOUR_WIRE:   four_wire  = cfg_data[0];
          default: ;
        endcase
      end
      pending <= pin_q.size();
    end
  end

endmodule

// ===== verif/spi_addr24_meter_master_tb.sv =====
// ============================================================================
// Serial meter master testbench
// Drives tick beats with random gaps and pin back-pressure, steps through a
// range of delay settings including zero and full scale, and lets the pin
// checker compare every pin beat against its own sequencer model.
// ============================================================================
module spi_addr24_meter_master_tb;
  import sam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat moving on either channel before the run is
  // declared hung. Every tick yields a pin beat, so real gaps are short.
  localparam int STALL_LIMIT = 2000;

  // A register index past the end of the list, written to show it is ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;
  int                   errors;
  int                   pending;
  int                   stall_cycles;

  // Stimulus knobs. When steady is set, neither side idles. When miso_hold is
  // set, the device data pin is held at miso_level instead of being random.
  logic steady;
  logic miso_hold;
  logic miso_level;

  // Configuration as last written, used to size the idle run after a request.
  int long_cfg;
  int half_cfg;

  sam_in_if  tick_ch ();
  sam_out_if pins_ch ();

  spi_addr24_meter_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .pins      (pins_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  spi_addr24_meter_master_chk i_chk (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_ch),
    .pins      (pins_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The pin side stalls in about a quarter of the cycles unless steady.
  always @(posedge clk) begin
    pins_ch.ready <= steady || ($urandom_range(99) >= 26);
  end

  // Watchdog: any accepted beat on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (pins_ch.valid && pins_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sends one tick beat and returns at the edge that accepts it. Before the
  // beat the sender may idle unless steady is set. Each call makes exactly one
  // assignment to valid per time step, so a back-to-back beat keeps valid high.
  task send_tick(input op_t func, input logic [HEADER_BITS-1:0] addr,
                 input logic [WORD_W-1:0] wval);
    if (!steady && $urandom_range(99) < 14) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.func        <= func;
    tick_ch.reg_addr    <= addr;
    tick_ch.write_value <= wval;
    tick_ch.miso_bit    <= miso_hold ? miso_level : 1'($urandom_range(1));
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // Runs n tick beats. A request shows up in req_pct percent of them; most
  // land in the middle of a frame and must be dropped, the rest start one.
  task run_ticks(input int n, input int req_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < req_pct)
        send_tick(op_t'($urandom_range(3, 1)), 8'($urandom), 24'($urandom));
      else
        send_tick(OP_NONE, 8'($urandom), 24'($urandom));
    end
  endtask

  // Upper bound on the ticks of one frame at the current settings: three long
  // waits, 32 bits of two half periods each, the tail and some slack.
  function int frame_bound();
    int l;
    int h;
    l = (long_cfg == 0) ? 1 : long_cfg;
    h = (half_cfg == 0) ? 1 : half_cfg;
    return 3 * l + 66 * h + 8;
  endfunction

  // One request, then enough idle ticks for its frame to close.
  task run_frame(input op_t func, input logic [HEADER_BITS-1:0] addr,
                 input logic [WORD_W-1:0] wval, input int req_pct);
    send_tick(func, addr, wval);
    run_ticks(frame_bound(), req_pct);
  endtask

  // Stops sending and waits until every pin beat has come back, so that
  // configuration writes never race a tick beat.
  task drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (3) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (idx == CFG_LONG_DELAY) long_cfg = data;
    if (idx == CFG_HALF_PERIOD) half_cfg = data;
  endtask

  task set_timing(input int l, input int h, input logic four_wire);
    drain();
    write_reg(CFG_LONG_DELAY, DELAY_W'(l));
    write_reg(CFG_HALF_PERIOD, DELAY_W'(h));
    write_reg(CFG_FOUR_WIRE, {{(DELAY_W-1){1'b0}}, four_wire});
  endtask

  // Delay settings of the random phases, zero among them.
  int rnd_long[3] = '{1, 2, 0};
  int rnd_half[3] = '{1, 3, 2};

  initial begin
    rst                 = 1'b1;
    cfg_wen             = 1'b0;
    cfg_index           = CFG_LONG_DELAY;
    cfg_data            = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.func        = OP_NONE;
    tick_ch.reg_addr    = '0;
    tick_ch.write_value = '0;
    tick_ch.miso_bit    = 1'b0;
    steady              = 1'b0;
    miso_hold           = 1'b0;
    miso_level          = 1'b0;
    long_cfg            = LONG_DELAY_RST;
    half_cfg            = HALF_PERIOD_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A few idle ticks at the reset settings: chip select high, clock, data
    // and the mode pin low, nothing stored yet.
    run_ticks(10, 0);

    // Directed frames at the fastest nonzero timing. Writes force the header
    // bits whatever the address, reads clear the top bit, commands go out
    // unchanged. Reads see an all-ones and an all-zeros data pin so that the
    // stored word and its scaled copy reach both ends. A few stray requests
    // during the first frame must be dropped.
    set_timing(1, 1, 1'b1);
    run_frame(OP_WRITE, 8'h40, 24'hFFFFFF, 1);
    miso_hold  = 1'b1;
    miso_level = 1'b1;
    run_frame(OP_READ, 8'hFF, 24'h000000, 0);
    miso_level = 1'b0;
    run_frame(OP_READ, 8'h00, 24'hFFFFFF, 0);
    miso_hold = 1'b0;
    run_frame(OP_CMD, 8'hFF, 24'hFFFFFF, 0);
    // Requests pile onto a busy frame, including on the tick it closes.
    run_frame(OP_CMD, 8'h10, 24'h5A5A5A, 40);

    // Zero in both delay registers acts as a one tick wait. The mode pin
    // write carries ones in its unused bits, which must be ignored, and the
    // index past the register list is ignored too.
    drain();
    write_reg(CFG_LONG_DELAY, '0);
    write_reg(CFG_HALF_PERIOD, '0);
    write_reg(CFG_FOUR_WIRE, 16'hFFFE);
    write_reg(CFG_UNUSED, 16'hFFFF);
    run_frame(OP_READ, 8'h7F, 24'h123456, 0);

    // Random phases over several settings. The first runs with no idling on
    // either side so the block sees back-to-back ticks and a free pin side.
    for (int p = 0; p < 3; p++) begin
      set_timing(rnd_long[p], rnd_half[p], 1'($urandom_range(1)));
      steady <= (p == 0);
      run_ticks((p == 0) ? 100 : 70, 15);
    end
    steady <= 1'b0;

    // The long wait register is lowered in the middle of the first wait:
    // the running wait keeps its length, later waits use the new one.
    set_timing(40, 1, 1'b1);
    send_tick(OP_READ, 8'($urandom), 24'($urandom));
    run_ticks(10, 1);
    drain();
    write_reg(CFG_LONG_DELAY, 16'd2);
    run_ticks(110, 5);

    // The half period is cut short the same way during the first clock high
    // of the header.
    set_timing(1, 30, 1'b0);
    send_tick(OP_CMD, 8'($urandom), 24'($urandom));
    run_ticks(10, 1);
    drain();
    write_reg(CFG_HALF_PERIOD, 16'd1);
    run_ticks(100, 5);

    // Full scale in both delay registers: the frame starts and holds its
    // first wait for the rest of the run.
    set_timing(65535, 65535, 1'b1);
    send_tick(OP_WRITE, 8'($urandom), 24'($urandom));
    run_ticks(20, 10);

    // Let every pin beat come home, then keep watching for anything the
    // block might still emit.
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
